// ===== rtl/fdec_pkg.sv =====
package fdec_pkg;

    localparam int FRAME_BYTES = 20;

    localparam int POS_W = 5;
    localparam logic [POS_W-1:0] POS_MAX   = 5'd31;
    localparam logic [POS_W-1:0] POS_FRAME = POS_W'(FRAME_BYTES);

    localparam logic [POS_W-1:0] POS_HDR0 = 5'd1;
    localparam logic [POS_W-1:0] POS_HDR1 = 5'd2;
    localparam logic [POS_W-1:0] POS_HDR2 = 5'd3;
    localparam logic [POS_W-1:0] POS_HDR3 = 5'd4;
    localparam logic [POS_W-1:0] POS_B12  = 5'd12;
    localparam logic [POS_W-1:0] POS_B14  = 5'd14;
    localparam logic [POS_W-1:0] POS_B16  = 5'd16;
    localparam logic [POS_W-1:0] POS_B18  = 5'd18;

    // restart pattern seen on bytes 1..4
    localparam logic [7:0] CRIT_B1 = 8'd10;
    localparam logic [7:0] CRIT_B2 = 8'd11;
    localparam logic [7:0] CRIT_B3 = 8'd2;
    localparam logic [7:0] CRIT_B4 = 8'd3;

    localparam logic [15:0] TIMEOUT_RESET = 16'd1000;
    localparam logic [15:0] IDLE_MAX      = 16'hFFFF;

    localparam int CFG_AW = 3;

    typedef enum logic [1:0] {
        REQ_BYTE = 2'd0,
        REQ_TICK = 2'd1,
        REQ_ARM  = 2'd2
    } req_t;

    typedef enum logic [1:0] {
        ST_NONE     = 2'd0,
        ST_TIMEOUT  = 2'd1,
        ST_CRITICAL = 2'd2,
        ST_DONE     = 2'd3
    } status_t;

    typedef struct packed {
        logic [7:0]  pulse_rate;
        logic [10:0] diastolic;
        logic [10:0] systolic;
        status_t     status;
    } result_t;

    // three BCD digits to binary
    function automatic logic [10:0] bcd3(input logic [3:0] h, input logic [3:0] t,
                                         input logic [3:0] o);
        logic [10:0] hv;
        logic [10:0] tv;
        hv = {7'd0, h} * 11'd100;
        tv = {7'd0, t} * 11'd10;
        return hv + tv + {7'd0, o};
    endfunction

endpackage

// ===== rtl/bp_monitor_frame_decoder.sv =====
// Blood-pressure monitor frame decoder. Each input beat carries a request kind
// in s_tuser (received byte, millisecond tick, arm) and a bus byte in s_tdata;
// every input beat yields exactly one output beat with a status in m_tuser and,
// on frame complete, systolic, diastolic and pulse rate in m_tdata. The block
// takes one beat per clock when the output side keeps up; each beat passes an
// input register and then the single-pass decode into the result register.
// timeout_ms is set through the APB port at address 0.
module bp_monitor_frame_decoder
    import fdec_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,   // [7:0] rx_byte
    input  logic [1:0]        s_tuser,   // [1:0] req_type
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [31:0]       m_tdata,   // [10:0] systolic, [21:11] diastolic,
                                         // [29:22] pulse_rate, [31:30] zero
    output logic [1:0]        m_tuser,   // [1:0] status
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic        in_valid_reg;
    logic        in_valid_next;
    logic [1:0]  in_req_reg;
    logic [7:0]  in_byte_reg;
    logic        res_valid_reg;
    logic        res_valid_next;
    result_t     res_reg;
    result_t     core_result;
    logic [15:0] timeout_ms;
    logic        out_free;
    logic        advance;

    fdec_cfg u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .timeout_ms (timeout_ms)
    );

    fdec_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .req_type   (in_req_reg),
        .rx_byte    (in_byte_reg),
        .timeout_ms (timeout_ms),
        .result     (core_result)
    );

    assign out_free = !res_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    always_comb
    begin
        in_valid_next  = in_valid_reg;
        res_valid_next = res_valid_reg;
        if (s_tready)
        begin
            in_valid_next = s_tvalid;
        end
        if (out_free)
        begin
            res_valid_next = advance;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // hold payloads while stalled
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_req_reg  <= s_tuser;
            in_byte_reg <= s_tdata;
        end
        if (advance)
        begin
            res_reg <= core_result;
        end
    end

    assign m_tvalid = res_valid_reg;
    assign m_tuser  = res_reg.status;
    assign m_tdata  = {2'b00, res_reg.pulse_rate, res_reg.diastolic, res_reg.systolic};

endmodule

// ===== rtl/fdec_cfg.sv =====
module fdec_cfg
    import fdec_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output logic [15:0]       timeout_ms
);

    logic [15:0] timeout_reg;
    logic [15:0] timeout_next;
    logic        sel_timeout;

    assign pready      = 1'b1;
    assign sel_timeout = (paddr[2] == 1'b0);

    always_comb
    begin
        timeout_next = timeout_reg;
        if (psel && penable && pwrite && sel_timeout)
        begin
            timeout_next = pwdata[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TIMEOUT_RESET;
        end
        else
        begin
            timeout_reg <= timeout_next;
        end
    end

    assign prdata     = sel_timeout ? {16'd0, timeout_reg} : 32'd0;
    assign timeout_ms = timeout_reg;

endmodule

// ===== rtl/fdec_core.sv =====
module fdec_core
    import fdec_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        advance,
    input  logic [1:0]  req_type,
    input  logic [7:0]  rx_byte,
    input  logic [15:0] timeout_ms,
    output result_t     result
);

    logic             listen_reg;
    logic             listen_next;
    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic [7:0]       hdr_reg [3];
    logic [7:0]       hdr_next [3];
    logic [7:0]       pay_reg [4];
    logic [7:0]       pay_next [4];
    logic [15:0]      idle_reg;
    logic [15:0]      idle_next;
    logic [POS_W-1:0] pos_base;
    logic [POS_W-1:0] pos_inc;
    logic             crit_hit;

    assign crit_hit = (hdr_reg[0] == CRIT_B1) && (hdr_reg[1] == CRIT_B2) &&
                      (hdr_reg[2] == CRIT_B3) && (rx_byte == CRIT_B4);

    always_comb
    begin
        listen_next = listen_reg;
        pos_next    = pos_reg;
        hdr_next    = hdr_reg;
        pay_next    = pay_reg;
        idle_next   = idle_reg;
        pos_base    = pos_reg;
        pos_inc     = pos_reg;
        result      = '0;
        result.status = ST_NONE;

        case (req_type)
            REQ_TICK:
            begin
                if (idle_reg != IDLE_MAX)
                begin
                    idle_next = idle_reg + 16'd1;
                end
            end
            REQ_ARM:
            begin
                if (!listen_reg)
                begin
                    listen_next = 1'b1;
                    pos_next    = '0;
                end
            end
            REQ_BYTE:
            begin
                if (listen_reg)
                begin
                    // a late byte ends listening and starts over as byte 1
                    if (idle_reg > timeout_ms)
                    begin
                        result.status = ST_TIMEOUT;
                        pos_base      = '0;
                        listen_next   = 1'b0;
                    end
                    idle_next = '0;
                    pos_inc   = (pos_base < POS_MAX) ? pos_base + 1'b1 : pos_base;
                    pos_next  = pos_inc;

                    case (pos_inc)
                        POS_HDR0: hdr_next[0] = rx_byte;
                        POS_HDR1: hdr_next[1] = rx_byte;
                        POS_HDR2: hdr_next[2] = rx_byte;
                        POS_HDR3:
                        begin
                            if (crit_hit)
                            begin
                                pos_next      = '0;
                                result.status = ST_CRITICAL;
                            end
                        end
                        POS_B12: pay_next[0] = rx_byte;
                        POS_B14: pay_next[1] = rx_byte;
                        POS_B16: pay_next[2] = rx_byte;
                        POS_B18: pay_next[3] = rx_byte;
                        default: ;
                    endcase

                    if (pos_next == POS_FRAME)
                    begin
                        result.status     = ST_DONE;
                        result.systolic   = bcd3(pay_next[0][7:4], pay_next[1][7:4],
                                                 pay_next[1][3:0]);
                        result.diastolic  = bcd3(pay_next[0][3:0], pay_next[2][7:4],
                                                 pay_next[2][3:0]);
                        result.pulse_rate = pay_next[3];
                        listen_next       = 1'b0;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            listen_reg <= 1'b0;
            pos_reg    <= '0;
            hdr_reg    <= '{default: '0};
            pay_reg    <= '{default: '0};
            idle_reg   <= '0;
        end
        else if (advance)
        begin
            listen_reg <= listen_next;
            pos_reg    <= pos_next;
            hdr_reg    <= hdr_next;
            pay_reg    <= pay_next;
            idle_reg   <= idle_next;
        end
    end

`ifndef SYNTHESIS
    a_pos_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_FRAME)
        else $error("byte position beyond frame length");

    a_done_stops: assert property (@(posedge clk) disable iff (!rst_n)
        advance && (result.status == ST_DONE) |=> !listen_reg)
        else $error("listening continues after frame complete");

    a_timeout_pos: assert property (@(posedge clk) disable iff (!rst_n)
        advance && (result.status == ST_TIMEOUT) |=> (pos_reg == POS_HDR0) && !listen_reg)
        else $error("timeout did not restart at byte one");

    a_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result.status != ST_DONE) |-> (result.systolic == '0) &&
        (result.diastolic == '0) && (result.pulse_rate == '0))
        else $error("measurement fields set without frame complete");
`endif

endmodule

// ===== tb/sv/bp_monitor_frame_decoder_tb.sv =====
`timescale 1ns / 1ps

module bp_monitor_frame_decoder_tb;
    import fdec_pkg::*;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 400;
    localparam int AGE_TICKS     = 6;
    localparam int AGE_FRAMES    = 3;
    localparam int RANDOM_QUOTA  = 220;
    localparam int GAP_PCT       = 26;

    localparam logic [1:0]        REQ_UNUSED   = 2'd3;
    localparam logic [CFG_AW-1:0] ADDR_TIMEOUT = '0;
    // restart pattern, byte 1 in the low bits
    localparam logic [31:0] CRIT_SEQ = {CRIT_B4, CRIT_B3, CRIT_B2, CRIT_B1};

    logic              clk;
    logic              rst_n   = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [7:0]        s_tdata = '0;
    logic [1:0]        s_tuser = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [31:0]       m_tdata;
    logic [1:0]        m_tuser;
    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [CFG_AW-1:0] paddr   = '0;
    logic [31:0]       pwdata  = '0;
    logic [31:0]       prdata;
    logic              pready;

    bp_monitor_frame_decoder dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // decoder state as the testbench sees it
    logic             armed       = 1'b0;
    logic [POS_W-1:0] frame_pos   = '0;
    logic [7:0]       hdr_byte [3];
    logic [7:0]       vital_byte [4];
    logic [15:0]      gap_ticks   = '0;
    logic [15:0]      timeout_lim = TIMEOUT_RESET;

    result_t pending_results [$];

    int  mismatches    = 0;
    int  beats_sent    = 0;
    int  results_seen  = 0;
    int  frames_done   = 0;
    int  timeouts_seen = 0;
    int  restarts_seen = 0;
    int  settings_made = 0;
    int  cycle_count   = 0;
    int  hold_request  = 0;
    bit  tx_gaps       = 1'b1;
    bit  rx_gaps       = 1'b1;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d, expected %0d (result %0d)", what, got, want,
                 results_seen);
        mismatches++;
    endtask

    function automatic result_t decode_beat(logic [1:0] kind, logic [7:0] b);
        result_t r;
        r = '0;
        r.status = ST_NONE;
        case (kind)
            REQ_TICK:
                if (gap_ticks != IDLE_MAX)
                    gap_ticks = gap_ticks + 16'd1;
            REQ_ARM:
                if (!armed)
                begin
                    armed = 1'b1;
                    frame_pos = '0;
                end
            REQ_BYTE:
                if (armed)
                begin
                    if (gap_ticks > timeout_lim)
                    begin
                        r.status = ST_TIMEOUT;
                        frame_pos = '0;
                        armed = 1'b0;
                    end
                    gap_ticks = '0;
                    if (frame_pos != POS_MAX)
                        frame_pos = frame_pos + 5'd1;
                    case (frame_pos)
                        POS_HDR0: hdr_byte[0] = b;
                        POS_HDR1: hdr_byte[1] = b;
                        POS_HDR2: hdr_byte[2] = b;
                        POS_HDR3:
                            if (hdr_byte[0] == CRIT_B1 && hdr_byte[1] == CRIT_B2 &&
                                hdr_byte[2] == CRIT_B3 && b == CRIT_B4)
                            begin
                                frame_pos = '0;
                                r.status = ST_CRITICAL;
                            end
                        POS_B12: vital_byte[0] = b;
                        POS_B14: vital_byte[1] = b;
                        POS_B16: vital_byte[2] = b;
                        POS_B18: vital_byte[3] = b;
                        default: ;
                    endcase
                    if (frame_pos == POS_FRAME)
                    begin
                        r.systolic   = {7'd0, vital_byte[0][7:4]} * 11'd100 +
                                       {7'd0, vital_byte[1][7:4]} * 11'd10 +
                                       {7'd0, vital_byte[1][3:0]};
                        r.diastolic  = {7'd0, vital_byte[0][3:0]} * 11'd100 +
                                       {7'd0, vital_byte[2][7:4]} * 11'd10 +
                                       {7'd0, vital_byte[2][3:0]};
                        r.pulse_rate = vital_byte[3];
                        r.status     = ST_DONE;
                        armed        = 1'b0;
                    end
                end
            default: ;
        endcase
        return r;
    endfunction

    task automatic send_item(logic [1:0] kind, logic [7:0] b);
        if (tx_gaps && $urandom_range(99) < GAP_PCT)
        begin
            s_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < GAP_PCT);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= b;
        do
            @(posedge clk);
        while (!s_tready);
        pending_results.push_back(decode_beat(kind, b));
        beats_sent++;
    endtask

    // hold the input off until every pending result is out, then let the block settle
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // optional write of timeout_ms, then read it back
    task automatic program_timeout(logic do_write, logic [15:0] value);
        logic [31:0] rd;
        if (do_write)
        begin
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= ADDR_TIMEOUT;
            pwdata  <= {16'd0, value};
            @(posedge clk);
            penable <= 1'b1;
            do
                @(posedge clk);
            while (!pready);
            timeout_lim = value;
            settings_made++;
        end
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_TIMEOUT;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rd = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (rd[15:0] != timeout_lim)
            report_mismatch("timeout_ms readback", rd[15:0], timeout_lim);
    endtask

    task automatic send_random_frame();
        int         n_bytes;
        int         ticks;
        logic [7:0] b;
        n_bytes = ($urandom_range(15) == 0) ? $urandom_range(1, FRAME_BYTES - 1)
                                            : FRAME_BYTES;
        send_item(REQ_ARM, 8'($urandom));
        if ($urandom_range(7) == 0)
        begin
            // restart pattern, sometimes with one byte spoiled
            for (int k = 0; k < 4; k++)
            begin
                b = CRIT_SEQ[8*k +: 8];
                if ($urandom_range(5) == 0)
                    b = 8'($urandom);
                send_item(REQ_BYTE, b);
            end
        end
        for (int i = 1; i <= n_bytes; i++)
        begin
            ticks = 0;
            if ($urandom_range(3) == 0)
                ticks = $urandom_range(0, (timeout_lim < 16'd4) ? int'(timeout_lim) : 4);
            if (timeout_lim <= 16'd64 && $urandom_range(39) == 0)
                ticks = int'(timeout_lim) + 1;
            repeat (ticks) send_item(REQ_TICK, 8'($urandom));
            if ($urandom_range(29) == 0)
                send_item($urandom_range(1) ? REQ_ARM : REQ_UNUSED, 8'($urandom));
            b = 8'($urandom);
            if (i <= 4 && $urandom_range(3) == 0)
                b = CRIT_SEQ[8*(i-1) +: 8];
            send_item(REQ_BYTE, b);
        end
    endtask

    // full frame at reset timeout, all BCD nibbles at 0xF, with a stray arm and an
    // unused request inside
    task automatic test_directed_frame();
        send_item(REQ_ARM, 8'h00);
        for (int i = 1; i <= FRAME_BYTES; i++)
        begin
            if (i == 5)
                send_item(REQ_ARM, 8'hFF);
            if (i == 9)
                send_item(REQ_UNUSED, 8'hFF);
            send_item(REQ_BYTE, (i % 2 == 1 || i >= 12) ? 8'hFF : 8'h00);
        end
    endtask

    task automatic test_special_cases();
        drain();
        program_timeout(1'b1, 16'd1);
        send_item(REQ_BYTE, 8'h5A);           // not listening: ignored
        send_item(REQ_ARM, 8'h00);
        for (int k = 0; k < 4; k++)
            send_item(REQ_BYTE, CRIT_SEQ[8*k +: 8]);
        send_item(REQ_BYTE, 8'hA5);
        send_item(REQ_TICK, 8'h00);
        send_item(REQ_BYTE, 8'h3C);           // gap equals the limit: still fine
        send_item(REQ_TICK, 8'hFF);
        send_item(REQ_TICK, 8'h00);
        send_item(REQ_BYTE, 8'hC3);           // gap over the limit
        send_item(REQ_BYTE, 8'h77);           // dropped after the timeout
    endtask

    // ticks age the gap while not listening and an arm keeps it; then a few frames
    // with no idling on either side
    task automatic test_idle_aging();
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
        drain();
        program_timeout(1'b1, 16'd3);
        repeat (AGE_TICKS) send_item(REQ_TICK, 8'($urandom));
        send_item(REQ_ARM, 8'h00);
        send_item(REQ_BYTE, 8'h12);
        repeat (AGE_FRAMES) send_random_frame();
        tx_gaps = 1'b1;
        rx_gaps = 1'b1;
    endtask

    task automatic test_backpressure();
        drain();
        program_timeout(1'b1, 16'd8);
        hold_request = HOLD_CYCLES;
        repeat (3) send_random_frame();
        drain();
    endtask

    task automatic test_random_traffic(logic [15:0] limit);
        int start;
        drain();
        program_timeout(1'b1, limit);
        start = beats_sent;
        while (beats_sent - start < RANDOM_QUOTA)
        begin
            if ($urandom_range(9) == 0)
                repeat ($urandom_range(1, 6))
                    send_item(2'($urandom_range(3)), 8'($urandom));
            else
                send_random_frame();
        end
    endtask

    // result side: random stalls, or a long hold when asked
    initial
    begin
        int hold;
        forever
        begin
            @(posedge clk);
            if (hold_request != 0)
            begin
                hold = hold_request;
                hold_request = 0;
                m_tready <= 1'b0;
                while (hold > 0)
                begin
                    @(posedge clk);
                    hold--;
                end
            end
            else
                m_tready <= !(rx_gaps && $urandom_range(99) < GAP_PCT);
        end
    end

    initial
    begin
        result_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
            begin
                results_seen++;
                if (pending_results.size() == 0)
                    report_mismatch("result with nothing pending, status", m_tuser, 0);
                else
                begin
                    want = pending_results.pop_front();
                    if (m_tuser != want.status)
                        report_mismatch("status", m_tuser, want.status);
                    if (m_tdata[10:0] != want.systolic)
                        report_mismatch("systolic", m_tdata[10:0], want.systolic);
                    if (m_tdata[21:11] != want.diastolic)
                        report_mismatch("diastolic", m_tdata[21:11], want.diastolic);
                    if (m_tdata[29:22] != want.pulse_rate)
                        report_mismatch("pulse_rate", m_tdata[29:22], want.pulse_rate);
                    case (want.status)
                        ST_DONE:     frames_done++;
                        ST_TIMEOUT:  timeouts_seen++;
                        ST_CRITICAL: restarts_seen++;
                        default: ;
                    endcase
                end
            end
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
            @(posedge clk);
        $display("run stopped at cycle %0d with %0d results outstanding", cycle_count,
                 pending_results.size());
        $display("bp_monitor_frame_decoder_tb failed");
        $finish;
    end

    initial
    begin
        for (int i = 0; i < 3; i++)
            hdr_byte[i] = '0;
        for (int i = 0; i < 4; i++)
            vital_byte[i] = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        program_timeout(1'b0, TIMEOUT_RESET);
        test_directed_frame();
        test_special_cases();
        test_idle_aging();
        test_backpressure();
        test_random_traffic(16'd1);
        test_random_traffic(16'($urandom_range(2, 16)));
        test_random_traffic(TIMEOUT_RESET);
        test_random_traffic(16'hFFFF);
        test_random_traffic(16'($urandom_range(17, 300)));

        drain();
        if (pending_results.size() != 0)
            report_mismatch("results never delivered", 0, pending_results.size());
        $display("sent %0d beats over %0d timeout settings, checked %0d results",
                 beats_sent, settings_made, results_seen);
        $display("frames decoded %0d, timeouts %0d, restart patterns %0d, %0d mismatches",
                 frames_done, timeouts_seen, restarts_seen, mismatches);
        if (mismatches == 0)
            $display("bp_monitor_frame_decoder_tb passed");
        else
            $display("bp_monitor_frame_decoder_tb failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/fdec_pkg.sv
rtl/fdec_cfg.sv
rtl/fdec_core.sv
rtl/bp_monitor_frame_decoder.sv
tb/sv/bp_monitor_frame_decoder_tb.sv
